[design/iida_pkg.sv]
package iida_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int POS_W = 5;
	localparam int CNT_W = 5;
	localparam int WORD_W = 32;
	localparam int TYPE_W = 2;
	localparam int STAT_W = 2;

	typedef enum logic [TYPE_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_READ   = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [POS_W-1:0]          pos;
		logic signed [WORD_W-1:0]  word;
	} cell_cmd_t;

endpackage

[design/iida_cell.sv]
module iida_cell import iida_pkg::*; (
	input  logic                      clk,
	input  logic [IDX_W-1:0]          idx,
	input  cell_cmd_t                 cmd,
	input  logic signed [WORD_W-1:0]  below_word,
	input  logic signed [WORD_W-1:0]  above_word,
	output logic signed [WORD_W-1:0]  word
);

	logic signed [WORD_W-1:0] word_q;
	logic [POS_W-1:0]         idx_ext;

	assign idx_ext = POS_W'(idx);
	assign word = word_q;

	// Insert moves everything at or past the position up one cell;
	// delete pulls everything at or past the position down one cell.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (idx_ext > cmd.pos) begin
					word_q <= below_word;
				end else if (idx_ext == cmd.pos) begin
					word_q <= cmd.word;
				end
			end
			CELL_DELETE: begin
				if (idx_ext >= cmd.pos) begin
					word_q <= above_word;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[design/indexed_insert_delete_array.sv]
// Result: a transaction's read word, entry count and status are registered
// when it is accepted and held at the output until out_ready takes them.
// Throughput: one transaction per cycle; every cell of the row shifts in
// parallel, so the output register's handshake is the only limit.
// Reset: arst_n clears the stored entry count and the output valid flag; the
// cell contents are left undefined and are never read before being written.
module indexed_insert_delete_array import iida_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [TYPE_W-1:0]         req_type,
	input  logic [POS_W-1:0]          position,
	input  logic signed [WORD_W-1:0]  insert_word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [WORD_W-1:0]  read_word,
	output logic [CNT_W-1:0]          entry_count,
	output logic [STAT_W-1:0]         status
);

	logic                     accept;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] read_word_q;
	logic signed [WORD_W-1:0] read_next;
	logic [CNT_W-1:0]         entry_count_q;
	status_t                  status_q;
	status_t                  status_next;
	cell_cmd_t                cmd;
	logic signed [WORD_W-1:0] cell_word [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		status_next = ST_DONE;
		count_next = count_q;
		read_next = '0;
		cmd.op = CELL_HOLD;
		cmd.pos = position;
		cmd.word = insert_word;
		unique case (req_type)
			REQ_INSERT: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					status_next = ST_FULL;
				end else if (position > count_q) begin
					status_next = ST_RANGE;
				end else begin
					cmd.op = CELL_INSERT;
					count_next = count_q + CNT_W'(1);
				end
			end
			REQ_DELETE: begin
				if (position >= count_q) begin
					status_next = ST_RANGE;
				end else begin
					cmd.op = CELL_DELETE;
					count_next = count_q - CNT_W'(1);
				end
			end
			REQ_READ: begin
				if (position >= count_q) begin
					status_next = ST_RANGE;
				end else begin
					read_next = cell_word[position[IDX_W-1:0]];
				end
			end
			default: begin
				status_next = ST_RANGE;
			end
		endcase
		if (!accept) begin
			cmd.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] below;
		logic signed [WORD_W-1:0] above;

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_mid_lo
			assign below = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign above = cell_word[i];
		end else begin : g_mid_hi
			assign above = cell_word[i+1];
		end

		iida_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.below_word (below),
			.above_word (above),
			.word       (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_word_q <= read_next;
			entry_count_q <= count_next;
			status_q <= status_next;
		end
	end

	assign out_valid = out_valid_q;
	assign read_word = read_word_q;
	assign entry_count = entry_count_q;
	assign status = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while a result is stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_FULL |-> entry_count_q == CNT_W'(CAPACITY))
		else $error("full status with list not full");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DONE |-> read_word_q == '0)
		else $error("nonzero read word on a failed request");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> entry_count_q == count_q)
		else $error("reported count differs from stored count");

endmodule

[sim/tb_top.sv]
module tb_top;
	import iida_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int LONG_HOLD = 200;
	localparam int RANDOM_ITEMS = 1800;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [WORD_W-1:0] word;
		logic [CNT_W-1:0]         count;
		status_t                  st;
	} list_reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [TYPE_W-1:0]        req_type = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [WORD_W-1:0] insert_word = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [WORD_W-1:0] read_word;
	logic [CNT_W-1:0]         entry_count;
	logic [STAT_W-1:0]        status;

	logic signed [WORD_W-1:0] shadow_words [CAPACITY];
	int                       shadow_len = 0;
	list_reply_t              awaited_replies [$];
	bit                       grow_list = 1'b1;
	int                       hold_requests = 0;
	int                       failures = 0;
	int unsigned              cycle_count = 0;

	indexed_insert_delete_array dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.position    (position),
		.insert_word (insert_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_word   (read_word),
		.entry_count (entry_count),
		.status      (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAIL indexed_insert_delete_array");
			$finish;
		end
	end

	function automatic list_reply_t apply_list_request(logic [TYPE_W-1:0] kind,
			logic [POS_W-1:0] pos, logic signed [WORD_W-1:0] word);
		list_reply_t r;
		int i;
		r.word = '0;
		r.st = ST_DONE;
		case (kind)
			REQ_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					r.st = ST_FULL;
				end else if (int'(pos) > shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = shadow_len; i > int'(pos); i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[pos] = word;
					shadow_len++;
				end
			end
			REQ_DELETE: begin
				if (int'(pos) >= shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = int'(pos); i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
				end
			end
			REQ_READ: begin
				if (int'(pos) >= shadow_len)
					r.st = ST_RANGE;
				else
					r.word = shadow_words[pos];
			end
			default: r.st = ST_RANGE;
		endcase
		r.count = CNT_W'(shadow_len);
		return r;
	endfunction

	function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
				$signed(want_v), $signed(got_v));
			failures++;
		end
	endfunction

	// A transaction is judged at the falling edge before the rising edge that takes it.
	always @(negedge clk) begin
		list_reply_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual %0d %0d %0d",
					$time, read_word, entry_count, status);
				failures++;
			end else begin
				want = awaited_replies.pop_front();
				check_field("read_word", want.word, read_word);
				check_field("entry_count", 32'(want.count), 32'(entry_count));
				check_field("status", 32'(want.st), 32'(status));
			end
		end
	end

	initial begin : reply_sink
		int mode;
		int left;
		int tick;
		int k;
		int holds_served;
		mode = 0;
		left = 0;
		tick = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				for (k = 0; k < LONG_HOLD; k++) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 160);
			end
			left--;
			tick++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (tick % 5) < 3;
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_request(input logic [TYPE_W-1:0] kind, input int pos,
			input logic signed [WORD_W-1:0] word);
		req_type <= kind;
		position <= POS_W'(pos);
		insert_word <= word;
		in_valid <= 1'b1;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		awaited_replies.push_back(apply_list_request(kind, POS_W'(pos), word));
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
	endtask

	task automatic pick_request(output logic [TYPE_W-1:0] kind, output int pos,
			output logic signed [WORD_W-1:0] word);
		int roll;
		if (shadow_len == CAPACITY)
			grow_list = 1'b0;
		else if (shadow_len == 0)
			grow_list = 1'b1;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			kind = REQ_UNUSED;
		else if (roll < (grow_list ? 60 : 30))
			kind = REQ_INSERT;
		else if (roll < 75)
			kind = REQ_DELETE;
		else
			kind = REQ_READ;
		case ($urandom_range(0, 11))
			0: word = 32'sh7fff_ffff;
			1: word = 32'sh8000_0000;
			2: word = '0;
			3: word = -1;
			default: word = $urandom;
		endcase
		if ($urandom_range(0, 9) == 0)
			pos = $urandom_range(0, 31);
		else if (kind == REQ_INSERT)
			pos = $urandom_range(0, shadow_len);
		else if (shadow_len == 0)
			pos = 0;
		else
			pos = $urandom_range(0, shadow_len - 1);
	endtask

	task automatic test_empty_list();
		send_request(REQ_READ, 0, 32'sd5);
		send_request(REQ_DELETE, 0, 32'sd0);
		send_request(REQ_INSERT, 1, 32'sd9);
		send_request(REQ_UNUSED, 31, -1);
		drain_replies();
	endtask

	task automatic test_ends_and_middle();
		send_request(REQ_INSERT, 0, 32'sh7fff_ffff);
		send_request(REQ_INSERT, 1, 32'sh8000_0000);
		send_request(REQ_INSERT, 1, -1);
		send_request(REQ_INSERT, 0, 32'sd0);
		send_request(REQ_INSERT, 5, 32'sd1);
		send_request(REQ_READ, 0, 32'sd0);
		send_request(REQ_READ, 1, 32'sd0);
		send_request(REQ_READ, 2, 32'sd0);
		send_request(REQ_READ, 3, 32'sd0);
		send_request(REQ_READ, 4, 32'sd0);
		send_request(REQ_DELETE, 3, 32'sd0);
		send_request(REQ_DELETE, 0, 32'sd0);
		send_request(REQ_READ, 0, 32'sd0);
		send_request(REQ_READ, 1, 32'sd0);
		send_request(REQ_DELETE, 2, 32'sd0);
		send_request(REQ_DELETE, 1, 32'sd0);
		send_request(REQ_DELETE, 0, 32'sd0);
		drain_replies();
	endtask

	task automatic test_full_list();
		while (shadow_len < CAPACITY)
			send_request(REQ_INSERT, $urandom_range(0, shadow_len), $urandom);
		send_request(REQ_INSERT, 31, 32'sd3);
		send_request(REQ_INSERT, 0, 32'sd4);
		send_request(REQ_INSERT, CAPACITY, 32'sd5);
		send_request(REQ_READ, CAPACITY - 1, 32'sd0);
		send_request(REQ_READ, CAPACITY, 32'sd0);
		send_request(REQ_DELETE, CAPACITY - 1, 32'sd0);
		send_request(REQ_DELETE, 0, 32'sd0);
		while (shadow_len > 0)
			send_request(REQ_DELETE, $urandom_range(0, shadow_len - 1), 32'sd0);
		drain_replies();
	endtask

	task automatic test_backpressure();
		logic [TYPE_W-1:0] kind;
		int pos;
		logic signed [WORD_W-1:0] word;
		int k;
		hold_requests++;
		for (k = 0; k < 48; k++) begin
			pick_request(kind, pos, word);
			send_request(kind, pos, word);
		end
		drain_replies();
	endtask

	task automatic test_random_traffic();
		logic [TYPE_W-1:0] kind;
		int pos;
		logic signed [WORD_W-1:0] word;
		int sent;
		int burst;
		int k;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			if ($urandom_range(0, 9) == 0)
				grow_list = !grow_list;
			for (k = 0; k < burst; k++) begin
				pick_request(kind, pos, word);
				send_request(kind, pos, word);
			end
			sent += burst;
			if ($urandom_range(0, 39) == 0)
				drain_replies();
			else if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 8));
		end
		drain_replies();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_ends_and_middle();
		test_full_list();
		test_backpressure();
		test_random_traffic();
		test_backpressure();
		drain_replies();
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("PASS indexed_insert_delete_array");
		end else begin
			$display("FAIL indexed_insert_delete_array");
		end
		$finish;
	end

endmodule

[sim.f]
design/iida_pkg.sv
design/iida_cell.sv
design/indexed_insert_delete_array.sv
sim/tb_top.sv
